// ----- rtl/hisp_pkg.sv -----
// hisp_pkg: shared types and constants of the half-image shift correlation peak block
// used by hisp_front, hisp_queue, hisp_back and half_image_shift_correlation_peak
// no dependencies
`default_nettype none

package hisp_pkg;

    // field and register widths
    localparam int unsigned PIX_W    = 8;
    localparam int unsigned SHIFT_W  = 9;
    localparam int unsigned SCORE_W  = 32;
    localparam int unsigned ROWS_W   = 9;
    localparam int unsigned COLS_W   = 9;
    localparam int unsigned START_W  = 8;
    localparam int unsigned STRIDE_W = 9;
    localparam int unsigned HALF_W   = COLS_W - 1;
    localparam int unsigned H_W      = ROWS_W + 1;

    // apb register map
    localparam int unsigned PADDR_W  = 4;
    localparam int unsigned PDATA_W  = 32;

    // entries of the queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;

    // register reset values
    localparam logic [ROWS_W-1:0]   ROWS_RST   = ROWS_W'(256);
    localparam logic [COLS_W-1:0]   COLS_RST   = COLS_W'(256);
    localparam logic [START_W-1:0]  START_RST  = '0;
    localparam logic [STRIDE_W-1:0] STRIDE_RST = STRIDE_W'(1);

    // register indexes
    typedef enum logic [1:0] {
        REG_ROWS,
        REG_COLS,
        REG_START,
        REG_STRIDE
    } hisp_reg_t;

    // configuration seen by the search engine
    typedef struct packed {
        logic [ROWS_W-1:0]   image_rows;
        logic [COLS_W-1:0]   image_cols;
        logic [START_W-1:0]  start_shift;
        logic [STRIDE_W-1:0] shift_stride;
    } hisp_cfg_t;

    // item class decided by the front
    typedef struct packed {
        logic wr;    // store the pixel
        logic srch;  // run the search afterwards
    } hisp_cmd_t;

    // back engine states
    typedef enum logic [2:0] {
        B_IDLE,
        B_SETUP,
        B_HMUL,
        B_RUN,
        B_DRAIN,
        B_OUT
    } hisp_state_t;

endpackage

`default_nettype wire

// ----- rtl/hisp_front.sv -----
// hisp_front: accepts pixel items, keeps the load count and classifies each item
// depends on hisp_pkg
`default_nettype none

module hisp_front #(
    parameter int unsigned MAX_ROWS = 256,
    parameter int unsigned MAX_COLS = 256
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 s_valid,
    output logic                                s_ready,
    input  wire [hisp_pkg::PIX_W-1:0]           s_pixel,
    input  wire                                 s_last_pixel,
    input  wire                                 q_ready,
    output logic                                q_push,
    output hisp_pkg::hisp_cmd_t                 q_cmd,
    output logic [$clog2(MAX_ROWS*MAX_COLS)-1:0] q_addr,
    output logic [hisp_pkg::PIX_W-1:0]          q_pixel
);

    localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned CW    = AW + 1;

    logic [CW-1:0] load_count_reg;
    logic [CW-1:0] load_count_next;
    logic          accept;
    logic          has_room;

    // classify the item
    assign s_ready    = q_ready;
    assign accept     = s_valid & s_ready;
    assign has_room   = load_count_reg < CW'(DEPTH);
    assign q_cmd.wr   = has_room;
    assign q_cmd.srch = s_last_pixel;
    assign q_push     = accept & (has_room | s_last_pixel);
    assign q_addr     = load_count_reg[AW-1:0];
    assign q_pixel    = s_pixel;

    // load count: next store entry, back to zero after the last pixel
    always_comb begin
        load_count_next = load_count_reg;
        if (accept) begin
            if (s_last_pixel) begin
                load_count_next = '0;
            end else if (has_room) begin
                load_count_next = load_count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_count_reg <= '0;
        end else begin
            load_count_reg <= load_count_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/hisp_queue.sv -----
// hisp_queue: short first-in first-out queue of classified items
// depends on hisp_pkg
`default_nettype none

module hisp_queue #(
    parameter int unsigned W = 20
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          push,
    input  wire [W-1:0]  push_data,
    output logic         push_ready,
    input  wire          pop,
    output logic         pop_valid,
    output logic [W-1:0] pop_data
);

    localparam int unsigned QD  = hisp_pkg::QUEUE_DEPTH;
    localparam int unsigned QAW = $clog2(QD);

    logic [W-1:0]   entry_reg [QD];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QAW:0]   count_reg;
    logic           do_push;
    logic           do_pop;

    assign push_ready = count_reg != (QAW+1)'(QD);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push & push_ready;
    assign do_pop     = pop & pop_valid;

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == QAW'(QD - 1)) ? '0 : wr_ptr_reg + QAW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QAW'(QD - 1)) ? '0 : rd_ptr_reg + QAW'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + (QAW+1)'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - (QAW+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/hisp_back.sv -----
// hisp_back: pixel store, shift search engine with one multiply-accumulate, result register
// depends on hisp_pkg
`default_nettype none

module hisp_back #(
    parameter int unsigned MAX_ROWS = 256,
    parameter int unsigned MAX_COLS = 256
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  hisp_pkg::hisp_cfg_t                  cfg,
    input  wire                                  q_valid,
    output logic                                 q_pop,
    input  hisp_pkg::hisp_cmd_t                  q_cmd,
    input  wire [$clog2(MAX_ROWS*MAX_COLS)-1:0]  q_addr,
    input  wire [hisp_pkg::PIX_W-1:0]            q_pixel,
    output logic                                 m_valid,
    input  wire                                  m_ready,
    output logic signed [hisp_pkg::SHIFT_W-1:0]  m_best_shift,
    output logic [hisp_pkg::SCORE_W-1:0]         m_best_score
);

    localparam int unsigned PIX_W    = hisp_pkg::PIX_W;
    localparam int unsigned SHIFT_W  = hisp_pkg::SHIFT_W;
    localparam int unsigned SCORE_W  = hisp_pkg::SCORE_W;
    localparam int unsigned ROWS_W   = hisp_pkg::ROWS_W;
    localparam int unsigned COLS_W   = hisp_pkg::COLS_W;
    localparam int unsigned HALF_W   = hisp_pkg::HALF_W;
    localparam int unsigned H_W      = hisp_pkg::H_W;
    localparam int unsigned DEPTH    = MAX_ROWS * MAX_COLS;
    localparam int unsigned AW       = $clog2(DEPTH);
    localparam int unsigned BW       = AW + 1;
    localparam int unsigned MW       = H_W + COLS_W;
    localparam int unsigned PROD_W   = 2 * PIX_W;
    localparam int unsigned ACC_W    = (PROD_W + AW > SCORE_W) ? PROD_W + AW : SCORE_W + 1;

    // pixel store, undefined until written
    logic [PIX_W-1:0] store_mem [DEPTH];

    hisp_pkg::hisp_state_t state_reg;
    hisp_pkg::hisp_state_t state_next;

    // effective configuration
    logic [ROWS_W-1:0] rows_eff;
    logic [COLS_W-1:0] cols_eff;
    logic [HALF_W-1:0] half;
    logic [H_W-1:0]    stride_eff;

    // search loop state
    logic [H_W-1:0]    h_reg;
    logic [BW-1:0]     hcols_reg;
    logic [BW-1:0]     base_lo_reg;
    logic [BW-1:0]     base_hi_reg;
    logic [ROWS_W-1:0] r_reg;
    logic [ROWS_W-1:0] r_last_reg;
    logic [HALF_W-1:0] y_reg;
    logic              dir_reg;

    logic [MW-1:0]     hcols_full;
    logic [H_W-1:0]    h_next;
    logic              y_end;
    logic              sum_end;
    logic              no_search;
    logic [BW-1:0]     left_base;
    logic [BW-1:0]     right_base;
    logic [BW-1:0]     addr_a_full;
    logic [BW-1:0]     addr_b_full;
    logic [SHIFT_W-1:0] tag;

    // multiply-accumulate pipeline
    logic               v1_reg;
    logic               last1_reg;
    logic [SHIFT_W-1:0] tag1_reg;
    logic [PIX_W-1:0]   rd_a_reg;
    logic [PIX_W-1:0]   rd_b_reg;
    logic               v2_reg;
    logic               last2_reg;
    logic [SHIFT_W-1:0] tag2_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [ACC_W-1:0]   acc_sum;
    logic [SCORE_W-1:0] sum_sat;

    // peak and result register
    logic [SHIFT_W-1:0] peak_shift_reg;
    logic [SCORE_W-1:0] peak_value_reg;
    logic               m_valid_reg;
    logic [SHIFT_W-1:0] m_shift_reg;
    logic [SCORE_W-1:0] m_score_reg;
    logic               out_load;
    logic               issue;

    // saturate sizes to the store and clean up the stride
    assign rows_eff   = (32'(cfg.image_rows) > 32'(MAX_ROWS)) ? ROWS_W'(MAX_ROWS)
                                                                : cfg.image_rows;
    assign cols_eff   = (32'(cfg.image_cols) > 32'(MAX_COLS)) ? COLS_W'(MAX_COLS)
                                                                : cfg.image_cols;
    assign half       = cols_eff[COLS_W-1:1];
    assign stride_eff = (cfg.shift_stride == '0) ? H_W'(1) : H_W'(cfg.shift_stride);
    assign no_search  = (rows_eff == '0) || (half == '0)
                      || (H_W'(cfg.start_shift) >= H_W'(rows_eff));

    // loop bookkeeping
    assign hcols_full = MW'(h_reg) * MW'(cols_eff);
    assign h_next     = h_reg + stride_eff;
    assign y_end      = y_reg == half - HALF_W'(1);
    assign sum_end    = y_end && (r_reg == r_last_reg);

    // down pairs row r left with row r+h right, up swaps the two rows
    assign left_base   = dir_reg ? base_hi_reg : base_lo_reg;
    assign right_base  = dir_reg ? base_lo_reg : base_hi_reg;
    assign addr_a_full = left_base + BW'(y_reg);
    assign addr_b_full = right_base + BW'(half) + BW'(y_reg);
    assign tag         = dir_reg ? SHIFT_W'(H_W'(0) - h_reg) : SHIFT_W'(h_reg);

    assign issue    = state_reg == hisp_pkg::B_RUN;
    assign out_load = (state_reg == hisp_pkg::B_OUT) && (!m_valid_reg || m_ready);

    // next state and queue pop
    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        unique case (state_reg)
            hisp_pkg::B_IDLE: begin
                q_pop = q_valid;
                if (q_valid && q_cmd.srch) begin
                    state_next = hisp_pkg::B_SETUP;
                end
            end
            hisp_pkg::B_SETUP: begin
                state_next = no_search ? hisp_pkg::B_OUT : hisp_pkg::B_HMUL;
            end
            hisp_pkg::B_HMUL: begin
                state_next = hisp_pkg::B_RUN;
            end
            hisp_pkg::B_RUN: begin
                if (sum_end && dir_reg) begin
                    state_next = (h_next >= H_W'(rows_eff)) ? hisp_pkg::B_DRAIN
                                                             : hisp_pkg::B_HMUL;
                end
            end
            hisp_pkg::B_DRAIN: begin
                if (!v1_reg && !v2_reg) begin
                    state_next = hisp_pkg::B_OUT;
                end
            end
            hisp_pkg::B_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = hisp_pkg::B_IDLE;
                end
            end
            default: state_next = hisp_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hisp_pkg::B_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // store write port and the two registered read ports
    always_ff @(posedge aclk) begin
        if (q_pop && q_cmd.wr) begin
            store_mem[q_addr] <= q_pixel;
        end
        rd_a_reg <= store_mem[addr_a_full[AW-1:0]];
        rd_b_reg <= store_mem[addr_b_full[AW-1:0]];
    end

    // shift, row and column counters
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            hisp_pkg::B_SETUP: begin
                h_reg <= H_W'(cfg.start_shift);
            end
            hisp_pkg::B_HMUL: begin
                hcols_reg   <= BW'(hcols_full);
                base_hi_reg <= BW'(hcols_full);
                base_lo_reg <= '0;
                r_reg       <= '0;
                y_reg       <= '0;
                dir_reg     <= 1'b0;
                r_last_reg  <= ROWS_W'(H_W'(rows_eff) - h_reg - H_W'(1));
            end
            hisp_pkg::B_RUN: begin
                if (sum_end) begin
                    r_reg       <= '0;
                    y_reg       <= '0;
                    base_lo_reg <= '0;
                    base_hi_reg <= hcols_reg;
                    dir_reg     <= 1'b1;
                    if (dir_reg) begin
                        h_reg <= h_next;
                    end
                end else if (y_end) begin
                    y_reg       <= '0;
                    r_reg       <= r_reg + ROWS_W'(1);
                    base_lo_reg <= base_lo_reg + BW'(cols_eff);
                    base_hi_reg <= base_hi_reg + BW'(cols_eff);
                end else begin
                    y_reg <= y_reg + HALF_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // pipeline payload
    always_ff @(posedge aclk) begin
        last1_reg <= sum_end;
        tag1_reg  <= tag;
        last2_reg <= last1_reg;
        tag2_reg  <= tag1_reg;
        prod_reg  <= PROD_W'(rd_a_reg) * PROD_W'(rd_b_reg);
    end

    // accumulate and saturate
    assign acc_sum = acc_reg + ACC_W'(prod_reg);
    assign sum_sat = (|acc_sum[ACC_W-1:SCORE_W]) ? '1 : acc_sum[SCORE_W-1:0];

    // pipeline valids, accumulator and peak tracking
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            acc_reg        <= '0;
            peak_shift_reg <= '0;
            peak_value_reg <= '0;
        end else begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
            if (state_reg == hisp_pkg::B_SETUP) begin
                acc_reg        <= '0;
                peak_shift_reg <= '0;
                peak_value_reg <= '0;
            end else if (v2_reg) begin
                if (last2_reg) begin
                    acc_reg <= '0;
                    if (sum_sat > peak_value_reg) begin
                        peak_value_reg <= sum_sat;
                        peak_shift_reg <= tag2_reg;
                    end
                end else begin
                    acc_reg <= acc_sum;
                end
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_shift_reg <= peak_shift_reg;
            m_score_reg <= peak_value_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_best_shift = signed'(m_shift_reg);
    assign m_best_score = m_score_reg;

    // pipeline is empty whenever the engine waits for items
    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == hisp_pkg::B_IDLE) |-> (!v1_reg && !v2_reg))
        else $error("mac pipeline busy while idle");

    // a zero score always goes with a zero shift
    a_zero_peak: assert property (@(posedge aclk) disable iff (!aresetn)
        (peak_value_reg == '0) |-> (peak_shift_reg == '0))
        else $error("shift recorded without positive score");

    // counters stay inside the overlap while issuing
    a_run_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        issue |-> (y_reg < half) && (r_reg <= r_last_reg))
        else $error("search counter out of range");

    // no store write during a search
    a_no_pop_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (state_reg == hisp_pkg::B_IDLE))
        else $error("queue popped during search");

endmodule

`default_nettype wire

// ----- rtl/half_image_shift_correlation_peak.sv -----
// half_image_shift_correlation_peak: top level with apb registers, front, queue and back
// depends on hisp_pkg, hisp_front, hisp_queue, hisp_back
//
//  channel  ports                                   direction  handshake
//  input    s_pixel, s_last_pixel                   in         s_valid / s_ready
//  result   m_best_shift, m_best_score              out        m_valid / m_ready
//  config   psel penable pwrite paddr pwdata prdata  in/out     apb, pready tied high
//
// a pixel item is taken and, while the engine is idle, written to the store at
// the edge at which it leaves the four-entry queue; the last item starts the search, which
// is carried out by the single multiply-accumulate fed by two read ports of the store.
// synchronous active-low reset; no clearing pass. the input stalls only when the
// queue is full; the result waits in its own register.
`default_nettype none

module half_image_shift_correlation_peak #(
    parameter int unsigned MAX_ROWS = 256,
    parameter int unsigned MAX_COLS = 256
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  s_valid,
    output logic                                 s_ready,
    input  wire [hisp_pkg::PIX_W-1:0]            s_pixel,
    input  wire                                  s_last_pixel,
    output logic                                 m_valid,
    input  wire                                  m_ready,
    output logic signed [hisp_pkg::SHIFT_W-1:0]  m_best_shift,
    output logic [hisp_pkg::SCORE_W-1:0]         m_best_score,
    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire [hisp_pkg::PADDR_W-1:0]          paddr,
    input  wire [hisp_pkg::PDATA_W-1:0]          pwdata,
    output logic [hisp_pkg::PDATA_W-1:0]         prdata,
    output logic                                 pready
);

    localparam int unsigned AW = $clog2(MAX_ROWS * MAX_COLS);
    localparam int unsigned QW = $bits(hisp_pkg::hisp_cmd_t) + AW + hisp_pkg::PIX_W;

    hisp_pkg::hisp_cfg_t cfg_reg;
    hisp_pkg::hisp_reg_t reg_sel;
    logic                cfg_write;

    hisp_pkg::hisp_cmd_t        f_cmd;
    logic [AW-1:0]              f_addr;
    logic [hisp_pkg::PIX_W-1:0] f_pixel;
    logic                       f_push;
    logic                       q_ready;
    logic                       q_valid;
    logic                       q_pop;
    logic [QW-1:0]              q_data;
    hisp_pkg::hisp_cmd_t        b_cmd;
    logic [AW-1:0]              b_addr;
    logic [hisp_pkg::PIX_W-1:0] b_pixel;

    // configuration registers
    assign pready    = 1'b1;
    assign reg_sel   = hisp_pkg::hisp_reg_t'(paddr[3:2]);
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.image_rows   <= hisp_pkg::ROWS_RST;
            cfg_reg.image_cols   <= hisp_pkg::COLS_RST;
            cfg_reg.start_shift  <= hisp_pkg::START_RST;
            cfg_reg.shift_stride <= hisp_pkg::STRIDE_RST;
        end else if (cfg_write) begin
            unique case (reg_sel)
                hisp_pkg::REG_ROWS:   cfg_reg.image_rows   <= pwdata[hisp_pkg::ROWS_W-1:0];
                hisp_pkg::REG_COLS:   cfg_reg.image_cols   <= pwdata[hisp_pkg::COLS_W-1:0];
                hisp_pkg::REG_START:  cfg_reg.start_shift  <= pwdata[hisp_pkg::START_W-1:0];
                hisp_pkg::REG_STRIDE: cfg_reg.shift_stride <= pwdata[hisp_pkg::STRIDE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // register read back
    always_comb begin
        unique case (reg_sel)
            hisp_pkg::REG_ROWS:   prdata = hisp_pkg::PDATA_W'(cfg_reg.image_rows);
            hisp_pkg::REG_COLS:   prdata = hisp_pkg::PDATA_W'(cfg_reg.image_cols);
            hisp_pkg::REG_START:  prdata = hisp_pkg::PDATA_W'(cfg_reg.start_shift);
            hisp_pkg::REG_STRIDE: prdata = hisp_pkg::PDATA_W'(cfg_reg.shift_stride);
            default:              prdata = '0;
        endcase
    end

    // front: intake and classification
    hisp_front #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel      (s_pixel),
        .s_last_pixel (s_last_pixel),
        .q_ready      (q_ready),
        .q_push       (f_push),
        .q_cmd        (f_cmd),
        .q_addr       (f_addr),
        .q_pixel      (f_pixel)
    );

    // queue between front and back
    hisp_queue #(
        .W (QW)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (f_push),
        .push_data  ({f_cmd, f_addr, f_pixel}),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_data   (q_data)
    );

    assign {b_cmd, b_addr, b_pixel} = q_data;

    // back: store and search engine
    hisp_back #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_cmd        (b_cmd),
        .q_addr       (b_addr),
        .q_pixel      (b_pixel),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_best_shift (m_best_shift),
        .m_best_score (m_best_score)
    );

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// testbench: self-checking bench for half_image_shift_correlation_peak
// depends on hisp_pkg and the rtl of the block; predicts each peak from its own pixel store
// covers directed edge images and random images under random settings
`default_nettype none

module testbench;

    localparam int unsigned PIX_W    = hisp_pkg::PIX_W;
    localparam int unsigned SHIFT_W  = hisp_pkg::SHIFT_W;
    localparam int unsigned SCORE_W  = hisp_pkg::SCORE_W;
    localparam int unsigned ROWS_W   = hisp_pkg::ROWS_W;
    localparam int unsigned COLS_W   = hisp_pkg::COLS_W;
    localparam int unsigned START_W  = hisp_pkg::START_W;
    localparam int unsigned STRIDE_W = hisp_pkg::STRIDE_W;
    localparam int unsigned PADDR_W  = hisp_pkg::PADDR_W;
    localparam int unsigned PDATA_W  = hisp_pkg::PDATA_W;

    localparam int STORE_DEPTH = 256 * 256;
    localparam int STALL_LIMIT = 400000;
    localparam int COST_CAP    = 4000;
    localparam int ITEM_TARGET = 750;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last;
    } pix_item_t;

    typedef struct packed {
        logic [SHIFT_W-1:0] shift;
        logic [SCORE_W-1:0] score;
    } peak_t;

    typedef enum int {
        PIX_ANY,
        PIX_TINY,
        PIX_RAIL,
        PIX_FULL,
        PIX_ZERO
    } pix_mode_t;

    logic                aclk;
    logic                aresetn      = 1'b0;
    logic                s_valid      = 1'b0;
    logic                s_ready;
    logic [PIX_W-1:0]    s_pixel      = '0;
    logic                s_last_pixel = 1'b0;
    logic                m_valid;
    logic                m_ready      = 1'b0;
    logic [SHIFT_W-1:0]  m_best_shift;
    logic [SCORE_W-1:0]  m_best_score;
    logic                psel         = 1'b0;
    logic                penable      = 1'b0;
    logic                pwrite       = 1'b0;
    logic [PADDR_W-1:0]  paddr        = '0;
    logic [PDATA_W-1:0]  pwdata       = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // bench state
    pix_item_t           pixel_feed[$];
    peak_t               pending_peaks[$];
    logic [7:0]          frame_mem [0:STORE_DEPTH-1];
    hisp_pkg::hisp_cfg_t cfg_shadow;
    int                  fill_count   = 0;
    int                  written_top  = 0;
    int                  push_count   = 0;
    int                  acc_count    = 0;
    int                  fail_count   = 0;
    int                  quiet_cycles = 0;
    logic                pix_taken    = 1'b0;
    logic                steady       = 1'b0;
    pix_item_t           drv_item;

    half_image_shift_correlation_peak dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel      (s_pixel),
        .s_last_pixel (s_last_pixel),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_best_shift (m_best_shift),
        .m_best_score (m_best_score),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // clamp the register values the way the search uses them
    function automatic void effective(input hisp_pkg::hisp_cfg_t c, output int rows,
                                      output int cols, output int half, output int stride);
        rows   = (c.image_rows > 256) ? 256 : int'(c.image_rows);
        cols   = (c.image_cols > 256) ? 256 : int'(c.image_cols);
        half   = cols / 2;
        stride = (c.shift_stride == 0) ? 1 : int'(c.shift_stride);
    endfunction

    // cycles of multiply-accumulate work for one search
    function automatic int search_cost(input hisp_pkg::hisp_cfg_t c);
        int rows, cols, half, stride, total;
        effective(c, rows, cols, half, stride);
        total = 0;
        for (int h = c.start_shift; h < rows; h += stride)
            total += 2 * (rows - h) * half + 1;
        return total;
    endfunction

    // number of leading store entries the search reads
    function automatic int reads_needed(input hisp_pkg::hisp_cfg_t c);
        int rows, cols, half, stride;
        effective(c, rows, cols, half, stride);
        if (half == 0 || c.start_shift >= rows)
            return 0;
        return (rows - 1) * cols + 2 * half;
    endfunction

    // peak search over downward and upward shifts of the right half
    function automatic peak_t correlate_halves(input hisp_pkg::hisp_cfg_t c);
        int rows, cols, half, stride;
        longint unsigned dn, up;
        logic [SCORE_W-1:0] sum;
        peak_t best;
        effective(c, rows, cols, half, stride);
        best = '0;
        for (int h = c.start_shift; h < rows; h += stride) begin
            dn = 0;
            up = 0;
            for (int x = 0; x + h < rows; x++)
                for (int y = 0; y < half; y++)
                    dn += longint'(frame_mem[x*cols + y]) * frame_mem[(x+h)*cols + y + half];
            for (int x = h; x < rows; x++)
                for (int y = 0; y < half; y++)
                    up += longint'(frame_mem[x*cols + y]) * frame_mem[(x-h)*cols + y + half];
            sum = (dn > 64'hFFFF_FFFF) ? '1 : SCORE_W'(dn);
            if (sum > best.score) begin
                best.score = sum;
                best.shift = SHIFT_W'(h);
            end
            sum = (up > 64'hFFFF_FFFF) ? '1 : SCORE_W'(up);
            if (sum > best.score) begin
                best.score = sum;
                best.shift = SHIFT_W'(-h);
            end
        end
        return best;
    endfunction

    // store an accepted pixel; the last one of an image yields a peak
    function automatic void take_pixel(input logic [PIX_W-1:0] px, input logic last);
        if (fill_count < STORE_DEPTH) begin
            frame_mem[fill_count] = px;
            fill_count++;
        end
        if (last) begin
            pending_peaks.push_back(correlate_halves(cfg_shadow));
            fill_count = 0;
        end
        acc_count++;
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel(input pix_mode_t mode);
        case (mode)
            PIX_ANY:  return PIX_W'($urandom_range(255));
            PIX_TINY: return PIX_W'($urandom_range(1));
            PIX_RAIL: return $urandom_range(1) ? 8'hFF : 8'h00;
            PIX_FULL: return 8'hFF;
            default:  return 8'h00;
        endcase
    endfunction

    // queue one image; never let the search read a store entry not yet written
    task automatic queue_image(input int len, input pix_mode_t mode);
        int need;
        pix_item_t item;
        need = reads_needed(cfg_shadow);
        if (len < need && need > written_top)
            len = need;
        for (int i = 0; i < len; i++) begin
            item.pixel = pick_pixel(mode);
            item.last  = (i == len - 1);
            pixel_feed.push_back(item);
        end
        push_count += len;
        if (len > written_top)
            written_top = (len > STORE_DEPTH) ? STORE_DEPTH : len;
    endtask

    // apb write followed by a read back of the same register
    task automatic reg_write(input hisp_pkg::hisp_reg_t idx, input int unsigned val);
        logic [PDATA_W-1:0] want;
        case (idx)
            hisp_pkg::REG_ROWS:  cfg_shadow.image_rows   = ROWS_W'(val);
            hisp_pkg::REG_COLS:  cfg_shadow.image_cols   = COLS_W'(val);
            hisp_pkg::REG_START: cfg_shadow.start_shift  = START_W'(val);
            default:             cfg_shadow.shift_stride = STRIDE_W'(val);
        endcase
        case (idx)
            hisp_pkg::REG_ROWS:  want = PDATA_W'(cfg_shadow.image_rows);
            hisp_pkg::REG_COLS:  want = PDATA_W'(cfg_shadow.image_cols);
            hisp_pkg::REG_START: want = PDATA_W'(cfg_shadow.start_shift);
            default:             want = PDATA_W'(cfg_shadow.shift_stride);
        endcase
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * int'(idx));
        pwdata  <= PDATA_W'(val);
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== want) begin
            $display("%0t register %s read back: expected %0h got %0h",
                     $time, idx.name(), want, prdata);
            fail_count++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(input int unsigned rows, input int unsigned cols,
                              input int unsigned start, input int unsigned stride);
        reg_write(hisp_pkg::REG_ROWS, rows);
        reg_write(hisp_pkg::REG_COLS, cols);
        reg_write(hisp_pkg::REG_START, start);
        reg_write(hisp_pkg::REG_STRIDE, stride);
    endtask

    // hold the sender until every peak has come back and the block is quiet
    task automatic drain();
        while (acc_count != push_count || pending_peaks.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // short searches, and small images unless the store already holds what is read
    function automatic hisp_pkg::hisp_cfg_t random_config();
        hisp_pkg::hisp_cfg_t c;
        do begin
            if ($urandom_range(99) < 80) begin
                c.image_rows   = ROWS_W'($urandom_range(1, 6));
                c.image_cols   = COLS_W'($urandom_range(0, 10));
                c.start_shift  = START_W'($urandom_range(0, 3));
                c.shift_stride = STRIDE_W'($urandom_range(0, 3));
            end else begin
                c.image_rows   = ROWS_W'($urandom_range(511));
                c.image_cols   = COLS_W'($urandom_range(511));
                c.start_shift  = START_W'($urandom_range(255));
                c.shift_stride = STRIDE_W'($urandom_range(511));
            end
        end while (search_cost(c) > COST_CAP
                   || (reads_needed(c) > 80 && reads_needed(c) > written_top));
        return c;
    endfunction

    // mostly whole images, some with extra pixels, some shorter than the frame
    function automatic int random_len(input hisp_pkg::hisp_cfg_t c);
        int rows, cols, half, stride, cells, pick;
        effective(c, rows, cols, half, stride);
        cells = rows * cols;
        pick  = $urandom_range(99);
        if (cells >= 1 && cells <= 64 && pick < 60)
            return cells;
        if (cells >= 1 && cells <= 64 && pick < 80)
            return cells + $urandom_range(1, 8);
        return $urandom_range(1, 12);
    endfunction

    // pixel driver: holds an item until it is taken
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || pix_taken) begin
            if (pixel_feed.size() != 0 && (steady || $urandom_range(99) >= 23)) begin
                drv_item = pixel_feed.pop_front();
                s_valid      <= 1'b1;
                s_pixel      <= drv_item.pixel;
                s_last_pixel <= drv_item.last;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result back-pressure
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= steady || ($urandom_range(99) >= 23);
        end
    end

    // monitor: predict on accepted pixels, check each peak, watch for a hang
    always @(posedge aclk) begin
        peak_t want;
        if (!aresetn) begin
            pix_taken    <= 1'b0;
            quiet_cycles = 0;
        end else begin
            pix_taken <= s_valid && s_ready;
            if (s_valid && s_ready)
                take_pixel(s_pixel, s_last_pixel);
            if (m_valid && m_ready) begin
                if (pending_peaks.size() == 0) begin
                    $display("%0t unexpected peak: shift %0d score %0d",
                             $time, $signed(m_best_shift), m_best_score);
                    fail_count++;
                end else begin
                    want = pending_peaks.pop_front();
                    if (m_best_shift !== want.shift) begin
                        $display("%0t best_shift: expected %0d got %0d", $time,
                                 $signed(want.shift), $signed(m_best_shift));
                        fail_count++;
                    end
                    if (m_best_score !== want.score) begin
                        $display("%0t best_score: expected %0d got %0d", $time,
                                 want.score, m_best_score);
                        fail_count++;
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t no item moved for %0d cycles", $time, STALL_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // stimulus
    initial begin
        int n_img, phase;
        hisp_pkg::hisp_cfg_t pick;
        cfg_shadow = {hisp_pkg::ROWS_RST, hisp_pkg::COLS_RST, hisp_pkg::START_RST,
                      hisp_pkg::STRIDE_RST};
        phase = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // saturated pixels with a tie between down and up at shift zero, then an all-zero image
        set_config(2, 2, 0, 1);
        queue_image(4, PIX_FULL);
        queue_image(4, PIX_ZERO);
        drain();

        // odd column count, one shift tried
        set_config(3, 5, 1, 2);
        queue_image(15, PIX_ANY);
        drain();

        // zero rows
        set_config(0, 4, 0, 1);
        queue_image(1, PIX_ANY);
        drain();

        // one column, then none
        set_config(4, 1, 0, 1);
        queue_image(1, PIX_ANY);
        drain();
        set_config(3, 0, 0, 1);
        queue_image(2, PIX_ANY);
        drain();

        // start shift beyond the rows
        set_config(5, 4, 200, 3);
        queue_image(2, PIX_ANY);
        drain();

        // rows above the maximum with only the last shift in range, zero stride
        set_config(511, 2, 255, 0);
        queue_image(3, PIX_ANY);
        drain();

        // columns above the maximum, single row
        set_config(1, 511, 0, 511);
        queue_image(2, PIX_ANY);
        drain();

        // random settings, a few images each
        while (push_count < ITEM_TARGET) begin
            pick = random_config();
            set_config(pick.image_rows, pick.image_cols, pick.start_shift, pick.shift_stride);
            steady = (phase >= 4 && phase < 10);
            n_img  = $urandom_range(1, 5);
            repeat (n_img)
                queue_image(random_len(cfg_shadow), pix_mode_t'($urandom_range(0, 2)));
            drain();
            phase++;
        end
        steady = 1'b0;

        repeat (100) @(posedge aclk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
